/* sv/mml_pkg.sv */
// shared types and constants of the module map lexer
`timescale 1ns / 1ps
package mml_pkg;

  typedef enum logic [2:0] {
    KIND_STRING  = 3'd0,
    KIND_INTEGER = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_PUNC    = 3'd3,
    KIND_END     = 3'd4,
    KIND_INVALID = 3'd5
  } token_kind_e;

  localparam int unsigned MaxEvents = 4;
  localparam int unsigned EvIdxW    = 2;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChStar      = 8'h2a;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChUnderscore = 8'h5f;

  // one token event
  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  text_byte;
    logic        has_byte;
    logic        start;
    logic        done;
  } event_t;

  // all events caused by one input byte
  typedef struct packed {
    event_t [MaxEvents-1:0] evs;
    logic   [EvIdxW-1:0]    last_idx;
  } bundle_t;

endpackage

/* sv/mml_front.sv */
// front end: per-byte lexer state and event bundle generation
`timescale 1ns / 1ps
module mml_front import mml_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       byte_valid_i,
  input  logic       end_of_text_i,
  output logic       bundle_valid_o,
  output bundle_t    bundle_o
);

  typedef enum logic [8:0] {
    M_IDLE       = 9'b000000001,
    M_INT        = 9'b000000010,
    M_IDENT      = 9'b000000100,
    M_STR        = 9'b000001000,
    M_STR_ESC    = 9'b000010000,
    M_SLASH      = 9'b000100000,
    M_LINE       = 9'b001000000,
    M_BLOCK      = 9'b010000000,
    M_BLOCK_STAR = 9'b100000000
  } mode_e;

  mode_e mode_q, mode_d;
  logic  fresh_q, fresh_d;

  function automatic event_t make_ev(token_kind_e kind, logic [7:0] b, logic has,
                                     logic start, logic done);
    event_t e;
    e.kind      = kind;
    e.text_byte = has ? b : 8'h00;
    e.has_byte  = has;
    e.start     = start;
    e.done      = done;
    return e;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  always_comb begin
    event_t [MaxEvents-1:0] evs;
    logic   [2:0]           n;
    logic                   redo;
    logic   [7:0]           c;
    c      = in_byte_i;
    evs    = '0;
    n      = 3'd0;
    redo   = 1'b0;
    mode_d = mode_q;
    fresh_d = fresh_q;

    if (byte_valid_i) begin
      unique case (mode_q)
        M_INT: begin
          if (is_digit(c)) begin
            evs[n[1:0]] = make_ev(KIND_INTEGER, c, 1'b1, 1'b0, 1'b0);
            n = n + 3'd1;
          end else begin
            evs[n[1:0]] = make_ev(KIND_INTEGER, c, 1'b0, 1'b0, 1'b1);
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_digit(c) || is_alpha(c) || c == ChUnderscore) begin
            evs[n[1:0]] = make_ev(KIND_IDENT, c, 1'b1, 1'b0, 1'b0);
            n = n + 3'd1;
          end else begin
            evs[n[1:0]] = make_ev(KIND_IDENT, c, 1'b0, 1'b0, 1'b1);
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_STR: begin
          if (c == ChQuote) begin
            evs[n[1:0]] = make_ev(KIND_STRING, c, 1'b0, fresh_q, 1'b1);
            n = n + 3'd1;
            fresh_d = 1'b0;
            mode_d = M_IDLE;
          end else begin
            evs[n[1:0]] = make_ev(KIND_STRING, c, 1'b1, fresh_q, 1'b0);
            n = n + 3'd1;
            fresh_d = 1'b0;
            if (c == ChBackslash) mode_d = M_STR_ESC;
          end
        end
        M_STR_ESC: begin
          evs[n[1:0]] = make_ev(KIND_STRING, c, 1'b1, fresh_q, 1'b0);
          n = n + 3'd1;
          fresh_d = 1'b0;
          mode_d = M_STR;
        end
        M_SLASH: begin
          if (c == ChSlash) begin
            mode_d = M_LINE;
          end else if (c == ChStar) begin
            mode_d = M_BLOCK;
          end else begin
            evs[n[1:0]] = make_ev(KIND_PUNC, ChSlash, 1'b1, 1'b1, 1'b1);
            n = n + 3'd1;
            redo = 1'b1;
          end
        end
        M_LINE: begin
          if (c == ChNewline) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (c == ChStar) mode_d = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (c == ChSlash) mode_d = M_IDLE;
          else if (c != ChStar) mode_d = M_BLOCK;
        end
        default: begin
          redo = 1'b1;
        end
      endcase

      // byte is lexed from idle after idle or a token that it ended; whitespace starts no token
      if (redo) begin
        mode_d = M_IDLE;
        if (is_space(c)) begin
          mode_d = M_IDLE;
        end else if (c == ChQuote) begin
          mode_d  = M_STR;
          fresh_d = 1'b1;
        end else if (is_digit(c)) begin
          mode_d = M_INT;
          evs[n[1:0]] = make_ev(KIND_INTEGER, c, 1'b1, 1'b1, 1'b0);
          n = n + 3'd1;
        end else if (is_alpha(c) || c == ChUnderscore) begin
          mode_d = M_IDENT;
          evs[n[1:0]] = make_ev(KIND_IDENT, c, 1'b1, 1'b1, 1'b0);
          n = n + 3'd1;
        end else if (c == ChSlash) begin
          mode_d = M_SLASH;
        end else begin
          evs[n[1:0]] = make_ev(KIND_PUNC, c, 1'b1, 1'b1, 1'b1);
          n = n + 3'd1;
        end
      end
    end

    if (end_of_text_i) begin
      unique case (mode_d)
        M_INT: begin
          evs[n[1:0]] = make_ev(KIND_INTEGER, c, 1'b0, 1'b0, 1'b1);
          n = n + 3'd1;
          evs[n[1:0]] = make_ev(KIND_END, c, 1'b0, 1'b1, 1'b1);
          n = n + 3'd1;
        end
        M_IDENT: begin
          evs[n[1:0]] = make_ev(KIND_IDENT, c, 1'b0, 1'b0, 1'b1);
          n = n + 3'd1;
          evs[n[1:0]] = make_ev(KIND_END, c, 1'b0, 1'b1, 1'b1);
          n = n + 3'd1;
        end
        M_SLASH: begin
          evs[n[1:0]] = make_ev(KIND_PUNC, ChSlash, 1'b1, 1'b1, 1'b1);
          n = n + 3'd1;
          evs[n[1:0]] = make_ev(KIND_END, c, 1'b0, 1'b1, 1'b1);
          n = n + 3'd1;
        end
        M_STR, M_STR_ESC, M_BLOCK, M_BLOCK_STAR: begin
          evs[n[1:0]] = make_ev(KIND_INVALID, c, 1'b0, 1'b1, 1'b1);
          n = n + 3'd1;
        end
        default: begin
          evs[n[1:0]] = make_ev(KIND_END, c, 1'b0, 1'b1, 1'b1);
          n = n + 3'd1;
        end
      endcase
      mode_d  = M_IDLE;
      fresh_d = 1'b0;
    end

    bundle_valid_o    = accept_i && (n != 3'd0);
    bundle_o.evs      = evs;
    bundle_o.last_idx = EvIdxW'(n - 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      fresh_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

/* sv/mml_fifo.sv */
// short register queue of event bundles between front and back
`timescale 1ns / 1ps
module mml_fifo import mml_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bundle_t wr_data_i,
  input  logic    rd_i,
  output bundle_t rd_data_o,
  output logic    full_o,
  output logic    not_empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o      = (cnt_q == FullCnt);
  assign not_empty_o = (cnt_q != '0);
  assign rd_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (rd_i) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (wr_i && !rd_i) cnt_q <= cnt_q + CntW'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

/* sv/mml_back.sv */
// back end: unpacks a bundle into single events through the output register
`timescale 1ns / 1ps
module mml_back import mml_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  bundle_t q_data_i,
  output logic    q_pop_o,
  input  logic    pop,
  output logic    empty,
  output event_t  ev_o,
  output logic    last_o
);

  logic [EvIdxW-1:0] idx_q;
  logic              out_valid_q;
  event_t            ev_q;
  logic              last_q;
  logic              load, take, at_last;

  assign load    = !out_valid_q || pop;
  assign take    = load && q_valid_i;
  assign at_last = (idx_q == q_data_i.last_idx);
  assign q_pop_o = take && at_last;

  assign empty  = !out_valid_q;
  assign ev_o   = ev_q;
  assign last_o = last_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q   <= q_data_i.evs[idx_q];
      last_q <= at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) out_valid_q <= q_valid_i;
      if (take) idx_q <= at_last ? '0 : idx_q + EvIdxW'(1);
    end
  end

endmodule

/* sv/module_map_lexer.sv */
// Module map lexer: streaming tokenizer, one text byte per request.
// Input channel: drive in_byte_i, byte_valid_i and end_of_text_i with push;
// a request is taken at a clock edge with push high and full low. A request
// with byte_valid_i low carries only the end marker (or nothing at all).
// Output channel: while empty is low the oldest token event is on the
// result ports; pop high at a clock edge takes it. last_o marks the final
// event caused by one input request.
// Path: a taken request is written into the bundle queue; its first event is
// then loaded into the output register that drives the result ports.
// Throughput: one input request per cycle while full is low, pop is high and
// each request causes at most one event; the back end drains one event per
// cycle while pop is high, so a request causing up to 4 events holds it until
// all are taken. The QueueDepth-entry queue absorbs bursts; full rises when it fills.
// Reset: asynchronous, active low; the lexer returns to idle between
// tokens, the queue and output register are emptied.
// Stall: when pop stays low the current event holds and, once the queue is
// full, full stays high and no further input is taken.
`timescale 1ns / 1ps
module module_map_lexer import mml_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       byte_valid_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] token_kind_o,
  output logic [7:0] text_byte_o,
  output logic       has_byte_o,
  output logic       token_start_o,
  output logic       token_done_o,
  output logic       last_o
);

  logic    accept;
  logic    bundle_valid;
  bundle_t bundle;
  bundle_t q_data;
  logic    q_valid, q_pop, q_full;
  event_t  ev;

  assign full   = q_full;
  assign accept = push && !q_full;

  mml_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .in_byte_i,
    .byte_valid_i,
    .end_of_text_i,
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  mml_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i        (bundle_valid),
    .wr_data_i   (bundle),
    .rd_i        (q_pop),
    .rd_data_o   (q_data),
    .full_o      (q_full),
    .not_empty_o (q_valid)
  );

  mml_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .pop,
    .empty,
    .ev_o      (ev),
    .last_o
  );

  assign token_kind_o  = ev.kind;
  assign text_byte_o   = ev.text_byte;
  assign has_byte_o    = ev.has_byte;
  assign token_start_o = ev.start;
  assign token_done_o  = ev.done;

endmodule

/* sv/mml_checker.sv */
// port-level checks of the module map lexer and their bind
`timescale 1ns / 1ps
module mml_checker import mml_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] token_kind_o,
  input logic [7:0] text_byte_o,
  input logic       has_byte_o,
  input logic       token_start_o,
  input logic       token_done_o,
  input logic       last_o
);

  // a stalled event stays on the ports
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(token_kind_o) && $stable(text_byte_o)
      && $stable(has_byte_o) && $stable(token_start_o) && $stable(token_done_o)
      && $stable(last_o))
    else $error("result changed while stalled");

  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !has_byte_o |-> text_byte_o == 8'h00)
    else $error("text byte not cleared");

  // end and invalid close the text and are always the final event
  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (token_kind_o == KIND_END || token_kind_o == KIND_INVALID) |->
      token_start_o && token_done_o && !has_byte_o && last_o)
    else $error("malformed end event");

  a_punc_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && token_kind_o == KIND_PUNC |-> has_byte_o && token_start_o && token_done_o)
    else $error("malformed punctuation event");

endmodule

bind module_map_lexer mml_checker u_mml_checker (.*);
